>>> rtl/rmvmm_pkg.sv
// Shared constants and types for the running mean, variance, minimum and maximum block.
// No dependencies.
package rmvmm_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 32;
  localparam int unsigned COUNT_BITS_DEF  = 32;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned IN_W    = 224;
  localparam int unsigned OUT_W   = 224;
  localparam int unsigned SQ_W    = 64;
  localparam int unsigned ROOT_W  = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_MERGE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

endpackage

>>> rtl/running_mean_variance_min_max.sv
// Top level of the running mean, variance, minimum and maximum block.
// Depends on rmvmm_pkg.
//
// One transaction in gives one transaction out. Each item runs on one shared
// iterative datapath: a shift-add multiplier (one operand bit a cycle), a
// restoring divider (one quotient bit a cycle over the full accumulator) and
// a digit-by-digit square root. The accumulator width is
// W = max(2*(SAMPLE_BITS+1) + 2*COUNT_BITS, 64), and
// MB = max(SAMPLE_BITS+1, COUNT_BITS).
// s_axis_tready is high only while the block is idle.
module running_mean_variance_min_max #(
  parameter int unsigned SAMPLE_BITS = rmvmm_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = rmvmm_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // sample, other_count, other_mean, other_sum_sq, other_min, other_max
  input  logic [rmvmm_pkg::IN_W-1:0]    s_axis_tdata,
  // cmd
  input  logic [rmvmm_pkg::CMD_W-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // count_out, mean_out, variance_out, std_dev_out, min_out, max_out
  output logic [rmvmm_pkg::OUT_W-1:0]   m_axis_tdata
);
  import rmvmm_pkg::*;

  localparam int unsigned S    = SAMPLE_BITS;
  localparam int unsigned C    = COUNT_BITS;
  localparam int unsigned WP   = 2 * (S + 1) + 2 * C;
  localparam int unsigned W    = (WP > 64) ? WP : 64;
  localparam int unsigned MB   = (S + 1 > C) ? S + 1 : C;
  localparam int unsigned DV   = C + 1;
  localparam int unsigned CW   = $clog2(W + 1);
  localparam logic [63:0] SMAX = (64'd1 << (S - 1)) - 64'd1;
  localparam logic [63:0] SMIN = ~SMAX;
  localparam logic [63:0] CMAX = (64'd1 << C) - 64'd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PDIV, ST_PMUL1, ST_PMUL2, ST_MMUL1, ST_MDIV1, ST_MMUL2,
    ST_MMUL3, ST_MMUL4, ST_MDIV2, ST_VAR, ST_VDIV, ST_SQRT, ST_OUT
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      it_q;
  logic [W-1:0]       acc_q, ma_q;
  logic [MB-1:0]      mb_q;
  logic [DV-1:0]      dv_q;
  logic [DV-1:0]      rem_q;
  logic [C-1:0]       cnt_q, n_q, c2_q;
  logic [DV-1:0]      tot_q;
  logic [S-1:0]       mean_q, min_q, max_q;
  logic [63:0]        ssd_q, osum_q, var_q;
  logic               neg_q;
  logic [S:0]         m_q;
  logic [79:0]        src_q;
  logic [ROOT_W+1:0]  srem_q;
  logic [ROOT_W-1:0]  root_q;
  logic               out_valid_q;
  logic [OUT_W-1:0]   out_q;

  function automatic logic [S-1:0] clamp_s(input logic [31:0] v);
    logic [63:0] e;
    e = {{32{v[31]}}, v};
    if ($signed(e) > $signed(SMAX)) e = SMAX;
    if ($signed(e) < $signed(SMIN)) e = SMIN;
    return e[S-1:0];
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] shr16_sat(input logic [W-1:0] a);
    logic [W-1:0] sh;
    logic [W-1:0] hi;
    sh = a >> 16;
    hi = a >> 80;
    return (hi != '0) ? '1 : sh[63:0];
  endfunction

  // Shared multiply step
  logic [W-1:0] mul_nx;
  assign mul_nx = (acc_q << 1) + (mb_q[MB-1] ? ma_q : '0);

  // Shared divide step
  logic [DV:0]   dr;
  logic          dge;
  logic [DV:0]   dsub;
  assign dr   = {rem_q, acc_q[W-1]};
  assign dge  = dr >= {1'b0, dv_q};
  assign dsub = dr - {1'b0, dv_q};

  // Square root step
  logic [ROOT_W+3:0] sr2, strial, sdiff;
  logic              sge;
  assign sr2    = {srem_q, src_q[79:78]};
  assign strial = {2'b00, root_q, 2'b01};
  assign sge    = sr2 >= strial;
  assign sdiff  = sr2 - strial;

  // Input item decode
  logic [S-1:0]  x_in, om_in, omin_in, omax_in, xs;
  logic [C-1:0]  c2_in;
  logic [63:0]   c2_e;
  logic [DV-1:0] tot_in;
  logic [S:0]    d_in, m_in;
  logic [C-1:0]  n_in;
  cmd_e          cmd_in;

  assign cmd_in  = cmd_e'(s_axis_tuser);
  assign x_in    = clamp_s(s_axis_tdata[31:0]);
  assign om_in   = clamp_s(s_axis_tdata[95:64]);
  assign omin_in = clamp_s(s_axis_tdata[191:160]);
  assign omax_in = clamp_s(s_axis_tdata[223:192]);
  assign c2_e    = ({32'd0, s_axis_tdata[63:32]} > CMAX) ? CMAX : {32'd0, s_axis_tdata[63:32]};
  assign c2_in   = c2_e[C-1:0];
  assign tot_in  = {1'b0, cnt_q} + {1'b0, c2_in};
  assign xs      = (cmd_in == CMD_PUSH) ? x_in : om_in;
  assign d_in    = {xs[S-1], xs} - {mean_q[S-1], mean_q};
  assign m_in    = d_in[S] ? (~d_in + 1'b1) : d_in;
  assign n_in    = ({32'd0, cnt_q} < CMAX) ? cnt_q + 1'b1 : cnt_q;

  // Mean update with quotient from the accumulator
  logic [S:0] q_w, mean_nx;
  assign q_w     = acc_q[S:0];
  assign mean_nx = {mean_q[S-1], mean_q} + (neg_q ? (~q_w + 1'b1) : q_w);

  logic [DV-1:0] tot_sat;
  assign tot_sat = ({1'b0, tot_q} > {1'b0, CMAX[DV-1:0]}) ? {1'b0, CMAX[C-1:0]} : tot_q;

  // Output formatting
  logic [63:0] cnt_e, mean_e, min_e, max_e;
  logic [31:0] std_w;
  assign cnt_e  = {{(64-C){1'b0}}, cnt_q};
  assign mean_e = {{(64-S){mean_q[S-1]}}, mean_q};
  assign min_e  = {{(64-S){min_q[S-1]}}, min_q};
  assign max_e  = {{(64-S){max_q[S-1]}}, max_q};
  assign std_w  = (root_q > {{(ROOT_W-32){1'b0}}, 32'hFFFF_FFFF}) ? '1 : root_q[31:0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      it_q        <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      mean_q      <= '0;
      ssd_q       <= '0;
      min_q       <= SMAX[S-1:0];
      max_q       <= SMIN[S-1:0];
    end else begin
      if (out_valid_q && m_axis_tready && state_q != ST_OUT) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            neg_q  <= d_in[S];
            m_q    <= m_in;
            c2_q   <= c2_in;
            tot_q  <= tot_in;
            osum_q <= s_axis_tdata[159:96];
            unique case (cmd_in)
              CMD_PUSH: begin
                if ($signed(x_in) < $signed(min_q)) min_q <= x_in;
                if ($signed(x_in) > $signed(max_q)) max_q <= x_in;
                n_q     <= n_in;
                acc_q   <= {{(W-S-1){1'b0}}, m_in};
                dv_q    <= {1'b0, n_in};
                rem_q   <= '0;
                it_q    <= CW'(W);
                state_q <= ST_PDIV;
              end
              CMD_CLEAR: begin
                cnt_q   <= '0;
                mean_q  <= '0;
                ssd_q   <= '0;
                min_q   <= SMAX[S-1:0];
                max_q   <= SMIN[S-1:0];
                state_q <= ST_VAR;
              end
              CMD_MERGE: begin
                if (tot_in == '0) begin
                  cnt_q   <= '0;
                  mean_q  <= '0;
                  ssd_q   <= '0;
                  min_q   <= SMAX[S-1:0];
                  max_q   <= SMIN[S-1:0];
                  state_q <= ST_VAR;
                end else begin
                  if ($signed(omin_in) < $signed(min_q)) min_q <= omin_in;
                  if ($signed(omax_in) > $signed(max_q)) max_q <= omax_in;
                  ma_q    <= {{(W-S-1){1'b0}}, m_in};
                  mb_q    <= {{(MB-C){1'b0}}, c2_in};
                  acc_q   <= '0;
                  it_q    <= CW'(MB);
                  state_q <= ST_MMUL1;
                end
              end
              CMD_NOP: state_q <= ST_VAR;
              default: state_q <= ST_VAR;
            endcase
          end
        end
        ST_PMUL1, ST_PMUL2, ST_MMUL1, ST_MMUL2, ST_MMUL3, ST_MMUL4: begin
          if (it_q != '0) begin
            acc_q <= mul_nx;
            mb_q  <= mb_q << 1;
            it_q  <= it_q - 1'b1;
          end else begin
            priority case (state_q)
              ST_PMUL1: begin
                ma_q    <= acc_q;
                mb_q    <= {{(MB-C){1'b0}}, cnt_q};
                acc_q   <= '0;
                it_q    <= CW'(MB);
                state_q <= ST_PMUL2;
              end
              ST_PMUL2: begin
                ssd_q   <= sat_add(ssd_q, shr16_sat(acc_q));
                cnt_q   <= n_q;
                state_q <= ST_VAR;
              end
              ST_MMUL1: begin
                rem_q   <= '0;
                dv_q    <= tot_q;
                it_q    <= CW'(W);
                state_q <= ST_MDIV1;
              end
              ST_MMUL2: begin
                ma_q    <= acc_q;
                mb_q    <= {{(MB-C){1'b0}}, cnt_q};
                acc_q   <= '0;
                it_q    <= CW'(MB);
                state_q <= ST_MMUL3;
              end
              ST_MMUL3: begin
                ma_q    <= acc_q;
                mb_q    <= {{(MB-C){1'b0}}, c2_q};
                acc_q   <= '0;
                it_q    <= CW'(MB);
                state_q <= ST_MMUL4;
              end
              default: begin
                rem_q   <= '0;
                dv_q    <= tot_q;
                it_q    <= CW'(W);
                state_q <= ST_MDIV2;
              end
            endcase
          end
        end
        ST_PDIV, ST_MDIV1, ST_MDIV2, ST_VDIV: begin
          if (it_q != '0) begin
            rem_q <= dge ? dsub[DV-1:0] : dr[DV-1:0];
            acc_q <= {acc_q[W-2:0], dge};
            it_q  <= it_q - 1'b1;
          end else begin
            priority case (state_q)
              ST_PDIV: begin
                mean_q  <= mean_nx[S-1:0];
                ma_q    <= {{(W-S-1){1'b0}}, m_q};
                mb_q    <= MB'(q_w);
                acc_q   <= '0;
                it_q    <= CW'(MB);
                state_q <= ST_PMUL1;
              end
              ST_MDIV1: begin
                mean_q  <= mean_nx[S-1:0];
                ma_q    <= {{(W-S-1){1'b0}}, m_q};
                mb_q    <= MB'(m_q);
                acc_q   <= '0;
                it_q    <= CW'(MB);
                state_q <= ST_MMUL2;
              end
              ST_MDIV2: begin
                ssd_q   <= sat_add(sat_add(ssd_q, osum_q), shr16_sat(acc_q));
                cnt_q   <= tot_sat[C-1:0];
                state_q <= ST_VAR;
              end
              default: begin
                var_q   <= acc_q[63:0];
                src_q   <= {acc_q[63:0], 16'd0};
                srem_q  <= '0;
                root_q  <= '0;
                it_q    <= CW'(ROOT_W);
                state_q <= ST_SQRT;
              end
            endcase
          end
        end
        ST_VAR: begin
          if (cnt_q > C'(1)) begin
            acc_q   <= {{(W-64){1'b0}}, ssd_q};
            dv_q    <= {1'b0, cnt_q - 1'b1};
            rem_q   <= '0;
            it_q    <= CW'(W);
            state_q <= ST_VDIV;
          end else begin
            var_q   <= '0;
            src_q   <= '0;
            srem_q  <= '0;
            root_q  <= '0;
            it_q    <= CW'(ROOT_W);
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (it_q != '0) begin
            srem_q <= sge ? sdiff[ROOT_W+1:0] : sr2[ROOT_W+1:0];
            root_q <= {root_q[ROOT_W-2:0], sge};
            src_q  <= src_q << 2;
            it_q   <= it_q - 1'b1;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_q       <= {max_e[31:0], min_e[31:0], std_w, var_q, mean_e[31:0],
                            cnt_e[31:0]};
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
